// ===== sv/ffba_pkg.sv =====
`default_nettype none

package ffba_pkg;

   localparam int NUM_BLOCKS  = 64;
   localparam int BLOCK_BYTES = 4;

   localparam int COUNT_W  = 9;
   localparam int OFFSET_W = 8;
   localparam int STATUS_W = 2;
   localparam int GRANT_W  = 8;

   localparam int BLK_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
   localparam int NBLK_W = COUNT_W;
   localparam int SUM_W  = COUNT_W + 1;
   localparam int CMP_W  = (CNT_W > NBLK_W) ? CNT_W : NBLK_W;
   localparam int PTR_W  = (CNT_W > OFFSET_W) ? CNT_W : OFFSET_W;
   localparam int PROD_W = BLK_W + 7;

   localparam logic ALLOCATE = 1'b0;
   localparam logic RELEASE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_ROOM   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FREED     = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_MARK,
      S_REPLY
   } state_type;

   typedef struct packed {
      logic             rd_en;
      logic [BLK_W-1:0] rd_addr;
      logic             wr_en;
      logic [BLK_W-1:0] wr_addr;
      logic             wr_data;
   } map_req_type;

   typedef struct packed {
      logic                valid;
      logic [STATUS_W-1:0] status;
      logic [GRANT_W-1:0]  offset;
   } reply_type;

endpackage

`default_nettype wire

// ===== sv/ffba_map.sv =====
`default_nettype none

module ffba_map (
   input  wire                  clock,
   input  wire                  reset,
   input  wire ffba_pkg::map_req_type map_req,
   output logic                 rd_data
);
   import ffba_pkg::*;

   logic                  mem_ff [NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0] valid_ff;
   logic                  rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (map_req.wr_en) begin
         valid_ff[map_req.wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (map_req.wr_en) begin
         mem_ff[map_req.wr_addr] <= map_req.wr_data;
      end
      if (map_req.rd_en) begin
         rd_data_ff <= valid_ff[map_req.rd_addr] & mem_ff[map_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/ffba_engine.sv =====
`default_nettype none

module ffba_engine (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            start,
   input  wire                            req_action,
   input  wire [ffba_pkg::COUNT_W-1:0]    req_count,
   input  wire [ffba_pkg::OFFSET_W-1:0]   req_offset,
   output logic                           idle,
   output ffba_pkg::map_req_type          map_req,
   input  wire                            rd_data,
   output ffba_pkg::reply_type            reply,
   input  wire                            reply_take
);
   import ffba_pkg::*;

   state_type           state_ff, state_in;
   logic                is_free_ff, is_free_in;
   logic [NBLK_W-1:0]   len_ff, len_in;
   logic [PTR_W-1:0]    ptr_ff, ptr_in;
   logic [CNT_W-1:0]    run_ff, run_in;
   logic                chk_ff, chk_in;
   logic [BLK_W-1:0]    chk_idx_ff, chk_idx_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [GRANT_W-1:0]  offset_ff, offset_in;

   logic [SUM_W-1:0]    sum;
   logic [NBLK_W-1:0]   nblk;
   logic [OFFSET_W-1:0] loc;
   logic [CNT_W-1:0]    run_inc;
   logic                hit;
   logic [CMP_W-1:0]    start_w;
   logic [BLK_W-1:0]    start_blk;
   logic [PROD_W-1:0]   prod;
   logic                ptr_in_pool;

   assign sum         = SUM_W'(req_count) + SUM_W'(BLOCK_BYTES - 1);
   assign nblk        = NBLK_W'(sum / BLOCK_BYTES);
   assign loc         = OFFSET_W'(req_offset / BLOCK_BYTES);
   assign run_inc     = run_ff + CNT_W'(1);
   assign hit         = chk_ff && !rd_data && (CMP_W'(run_inc) == CMP_W'(len_ff));
   assign start_w     = CMP_W'(chk_idx_ff) + CMP_W'(1) - CMP_W'(len_ff);
   assign start_blk   = start_w[BLK_W-1:0];
   assign prod        = PROD_W'(start_blk) * PROD_W'(BLOCK_BYTES);
   assign ptr_in_pool = ptr_ff < PTR_W'(NUM_BLOCKS);

   always_comb begin
      state_in   = state_ff;
      is_free_in = is_free_ff;
      len_in     = len_ff;
      ptr_in     = ptr_ff;
      run_in     = run_ff;
      chk_in     = 1'b0;
      chk_idx_in = chk_idx_ff;
      status_in  = status_ff;
      offset_in  = offset_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               is_free_in = (req_action == RELEASE);
               len_in     = nblk;
               offset_in  = '0;
               run_in     = '0;
               if (req_action == RELEASE) begin
                  ptr_in    = PTR_W'(loc);
                  status_in = ST_FREED;
                  state_in  = S_MARK;
               end else if (nblk == '0) begin
                  status_in = ST_ALLOCATED;
                  state_in  = S_REPLY;
               end else if (CMP_W'(nblk) > CMP_W'(NUM_BLOCKS)) begin
                  status_in = ST_NO_ROOM;
                  state_in  = S_REPLY;
               end else begin
                  ptr_in   = '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (ptr_in_pool) begin
               ptr_in     = ptr_ff + PTR_W'(1);
               chk_in     = 1'b1;
               chk_idx_in = ptr_ff[BLK_W-1:0];
            end
            if (chk_ff) begin
               run_in = rd_data ? '0 : run_inc;
               if (hit) begin
                  chk_in    = 1'b0;
                  ptr_in    = PTR_W'(start_blk);
                  status_in = ST_ALLOCATED;
                  offset_in = prod[GRANT_W-1:0];
                  state_in  = S_MARK;
               end else if (chk_idx_ff == BLK_W'(NUM_BLOCKS - 1)) begin
                  chk_in    = 1'b0;
                  status_in = ST_NO_ROOM;
                  state_in  = S_REPLY;
               end
            end
         end
         S_MARK: begin
            if (len_ff == '0 || !ptr_in_pool) begin
               state_in = S_REPLY;
            end else begin
               ptr_in = ptr_ff + PTR_W'(1);
               len_in = len_ff - NBLK_W'(1);
            end
         end
         S_REPLY: begin
            if (reply_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      idle         = 1'b0;
      map_req      = '0;
      reply        = '0;
      reply.status = status_ff;
      reply.offset = offset_ff;
      case (state_ff)
         S_IDLE: begin
            idle = 1'b1;
         end
         S_SCAN: begin
            map_req.rd_en   = ptr_in_pool;
            map_req.rd_addr = ptr_ff[BLK_W-1:0];
         end
         S_MARK: begin
            map_req.wr_en   = (len_ff != '0) && ptr_in_pool;
            map_req.wr_addr = ptr_ff[BLK_W-1:0];
            map_req.wr_data = !is_free_ff;
         end
         S_REPLY: begin
            reply.valid = 1'b1;
         end
         default: begin
            idle = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         chk_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         chk_ff   <= chk_in;
      end
   end

   always_ff @(posedge clock) begin
      is_free_ff <= is_free_in;
      len_ff     <= len_in;
      ptr_ff     <= ptr_in;
      run_ff     <= run_in;
      chk_idx_ff <= chk_idx_in;
      status_ff  <= status_in;
      offset_ff  <= offset_in;
   end

`ifndef SYNTHESIS
   a_no_write_in_scan : assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_MARK) |-> !map_req.wr_en)
      else $error("map write outside mark phase");

   a_busy_after_start : assert property (@(posedge clock) disable iff (reset)
      start |=> !idle)
      else $error("engine idle right after accepting a beat");

   a_mark_status : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MARK) |->
         ((is_free_ff && status_ff == ST_FREED) || (!is_free_ff && status_ff == ST_ALLOCATED)))
      else $error("mark phase with inconsistent status");

   a_hit_leaves_scan : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && hit) |=> (state_ff == S_MARK))
      else $error("found run did not start marking");
`endif

endmodule

`default_nettype wire

// ===== sv/first_fit_block_allocator_unit.sv =====
// channel  dir  tdata (low bit up)                    tuser
// req      in   byte_count[8:0], byte_offset[16:9]     action
// rsp      out  granted_offset[7:0]                    status[1:0]
//
// One request at a time, from the accepted beat to the response load.
// Allocate: the scan reads one block a cycle up to run end block k, then the mark writes
// n blocks one a cycle; a miss scans all NUM_BLOCKS blocks. Zero-byte or oversized
// allocate replies without a scan. Free writes the n covered blocks that lie in the pool.
// Reset clears the map at once through per-block valid flops.
// A full, stalled response register holds the reply; else the next beat is taken the next cycle.
`default_nettype none

module first_fit_block_allocator_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,   // byte_count[8:0], byte_offset[16:9], zero pad
   input  wire         req_tuser,   // action
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // granted_offset[7:0]
   output logic [1:0]  rsp_tuser    // status[1:0]
);
   import ffba_pkg::*;

   map_req_type         map_req;
   reply_type           reply;
   logic                rd_data;
   logic                idle;
   logic                start;
   logic                take;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [GRANT_W-1:0]  rsp_offset_ff, rsp_offset_in;

   assign req_tready = idle;
   assign start      = req_tvalid && idle;
   assign take       = !rsp_valid_ff || rsp_tready;

   ffba_map u_map (
      .clock   (clock),
      .reset   (reset),
      .map_req (map_req),
      .rd_data (rd_data)
   );

   ffba_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_tuser),
      .req_count  (req_tdata[COUNT_W-1:0]),
      .req_offset (req_tdata[COUNT_W+OFFSET_W-1:COUNT_W]),
      .idle       (idle),
      .map_req    (map_req),
      .rd_data    (rd_data),
      .reply      (reply),
      .reply_take (take)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      if (reply.valid && take) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = reply.status;
         rsp_offset_in = reply.offset;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_offset_ff;
   assign rsp_tuser  = rsp_status_ff;

`ifndef SYNTHESIS
   a_no_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (reply.valid && !take) |=> reply.valid)
      else $error("reply dropped while response register was full");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response beat changed");

   a_status_code : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == ST_ALLOCATED || rsp_tuser == ST_NO_ROOM
                      || rsp_tuser == ST_FREED))
      else $error("response status out of range");
`endif

endmodule

`default_nettype wire
